/* rtl/tbt_pkg.sv */
// Shared types and constants for the thermistor beta temperature block.
// No dependencies; imported by every module of the block.
package tbt_pkg;

   localparam int DIV_W = 58;
   localparam int LOG_W = 25;
   localparam int MANT_W = 31;
   localparam int CMP_W = 11;
   localparam int DEF_ADC_FULL_SCALE = 1023;
   localparam int DEF_MAX_SAMPLES = 64;

   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic signed [17:0] TEMP_LOW = -18'sd27315;
   localparam logic signed [17:0] TEMP_HIGH = 18'sd100000;
   localparam logic [17:0] KELVIN_OFFSET = 18'd27315;
   localparam logic [57:0] TC_HIGH = 58'd127315;
   localparam logic [23:0] RES_MAX = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REG_SAMPLE_COUNT = 3'd0,
      REG_SERIES       = 3'd1,
      REG_NOMINAL_RES  = 3'd2,
      REG_BETA         = 3'd3,
      REG_NOMINAL_TEMP = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_OPEN  = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_AVG, S_RES, S_LOGR, S_LOG0, S_LN, S_PROD, S_DEN, S_CHK, S_TDIV, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      L_IDLE, L_NORM, L_SQ
   } log_state_type;

endpackage

/* rtl/tbt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tbt_pkg for the datapath width.
module tbt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tbt_pkg::DIV_W-1:0] dividend,
   input  logic [tbt_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [tbt_pkg::DIV_W-1:0] quotient
);
   import tbt_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W:0]   rem_ff, rem_in, shifted;
   logic [DIV_W-1:0] quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/tbt_log2.sv */
// Fixed-point log2 in Q20: normalize one bit a cycle, then 20 squaring rounds.
// Depends on tbt_pkg for widths and the unit state type.
module tbt_log2 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tbt_pkg::MANT_W-1:0] x,
   output logic                       done,
   output logic [tbt_pkg::LOG_W-1:0]  result
);
   import tbt_pkg::*;

   log_state_type      state_ff, state_in;
   logic [MANT_W-1:0]  m_ff, m_in;
   logic [4:0]         k_ff, k_in, cnt_ff, cnt_in;
   logic [19:0]        frac_ff, frac_in;
   logic               done_ff, done_in;
   logic [61:0]        sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      m_ff    <= m_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      frac_ff <= frac_in;
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      frac_in  = frac_ff;
      done_in  = 1'b0;
      sq       = 62'(m_ff) * 62'(m_ff);
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               m_in     = x;
               k_in     = 5'd30;
               frac_in  = '0;
               cnt_in   = 5'd20;
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            if (m_ff[MANT_W-1]) begin
               state_in = L_SQ;
            end else begin
               m_in = {m_ff[MANT_W-2:0], 1'b0};
               k_in = k_ff - 1'b1;
            end
         end
         L_SQ: begin
            if (sq[61]) begin
               m_in    = sq[61:31];
               frac_in = {frac_ff[18:0], 1'b1};
            end else begin
               m_in    = sq[60:30];
               frac_in = {frac_ff[18:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) begin
               state_in = L_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   assign done   = done_ff;
   assign result = {k_ff, frac_ff};

endmodule

/* rtl/thermistor_beta_temperature.sv */
// Thermistor temperature by the beta equation. Samples are taken one per cycle while
// collecting. The item that completes the count stalls req_ for the averaging divide
// and S_OUT alone when the mean sits at either end of the scale, else for three divider
// passes, two log2 passes whose length is set by the operand width, and the five steps
// S_LN, S_PROD, S_DEN, S_CHK, S_OUT; a zero resistance skips to S_OUT and a zero or
// negative denominator skips the last divide. A result still held by rsp_stall adds to
// this. A finished item waits in the output register while the next collection proceeds.
module thermistor_beta_temperature #(
   parameter int ADC_FULL_SCALE = tbt_pkg::DEF_ADC_FULL_SCALE,
   parameter int MAX_SAMPLES    = tbt_pkg::DEF_MAX_SAMPLES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_adc_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_averaged_adc,
   output logic [23:0]        rsp_resistance_ohms,
   output logic signed [17:0] rsp_temperature_centi_c,
   output logic [1:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wr_data
);
   import tbt_pkg::*;

   localparam int SUM_W = $clog2(MAX_SAMPLES * 1024);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [15:0] FS = 16'(ADC_FULL_SCALE);
   localparam logic [CMP_W-1:0] MAXN = CMP_W'(MAX_SAMPLES);

   state_type state_ff, state_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [6:0]  count_ff;
   logic [19:0] series_ff;
   logic [23:0] r0_ff;
   logic [13:0] beta_ff;
   logic [15:0] tn_ff;
   logic [9:0]  avg_ff, avg_in;
   logic [LOG_W-1:0] lr_ff, lr_in;
   logic signed [25:0] d_ff, d_in, l_ff, l_in;
   logic [29:0] tnb_ff, tnb_in;
   logic [56:0] num_ff, num_in;
   logic signed [43:0] den_ff, den_in;
   logic [23:0] res_ff, res_in;
   logic signed [17:0] temp_ff, temp_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_avg_ff, rsp_avg_in;
   logic [23:0] rsp_res_ff, rsp_res_in;
   logic signed [17:0] rsp_temp_ff, rsp_temp_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic div_start, div_done, log_start, log_done;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_q;
   logic [MANT_W-1:0] log_x;
   logic [LOG_W-1:0]  log_q;

   logic [23:0] r0_eff;
   logic [13:0] beta_eff;
   logic [15:0] tn_eff;
   logic [CMP_W-1:0] n_eff, taken_next;
   logic [9:0]  s_sat;
   logic [25:0] mag;
   logic [55:0] mag_prod;
   logic [25:0] mag_l;
   logic signed [42:0] tnl;
   logic [20:0] b100;
   logic [57:0] tc;

   tbt_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_q)
   );

   tbt_log2 u_log2 (
      .clock(clock), .reset(reset), .start(log_start), .x(log_x),
      .done(log_done), .result(log_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 7'd8;
         series_ff    <= 20'd4700;
         r0_ff        <= 24'd100000;
         beta_ff      <= 14'd3950;
         tn_ff        <= 16'd29815;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_SAMPLE_COUNT: count_ff  <= csr_wr_data[6:0];
               REG_SERIES:       series_ff <= csr_wr_data[19:0];
               REG_NOMINAL_RES:  r0_ff     <= csr_wr_data;
               REG_BETA:         beta_ff   <= csr_wr_data[13:0];
               REG_NOMINAL_TEMP: tn_ff     <= csr_wr_data[15:0];
               default: ;
            endcase
         end
      end
      avg_ff        <= avg_in;
      lr_ff         <= lr_in;
      d_ff          <= d_in;
      l_ff          <= l_in;
      tnb_ff        <= tnb_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      res_ff        <= res_in;
      temp_ff       <= temp_in;
      status_ff     <= status_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      r0_eff   = (r0_ff == '0) ? 24'd1 : r0_ff;
      beta_eff = (beta_ff == '0) ? 14'd1 : beta_ff;
      tn_eff   = (tn_ff == '0) ? 16'd1 : tn_ff;
      if (count_ff == '0) begin
         n_eff = CMP_W'(1);
      end else if (CMP_W'(count_ff) > MAXN) begin
         n_eff = MAXN;
      end else begin
         n_eff = CMP_W'(count_ff);
      end
      s_sat      = ({6'd0, req_adc_sample} > FS) ? FS[9:0] : req_adc_sample;
      taken_next = CMP_W'(taken_ff) + CMP_W'(1);
      mag        = d_ff[25] ? 26'(-d_ff) : 26'(d_ff);
      mag_prod   = 56'(mag) * 56'(LN2_Q30);
      mag_l      = mag_prod[55:30];
      tnl        = 43'($signed({1'b0, tn_eff})) * 43'(l_ff);
      b100       = 21'(beta_eff) * 21'd100;
      tc         = div_q;

      state_in      = state_ff;
      sum_in        = sum_ff;
      taken_in      = taken_ff;
      avg_in        = avg_ff;
      lr_in         = lr_ff;
      d_in          = d_ff;
      l_in          = l_ff;
      tnb_in        = tnb_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      res_in        = res_ff;
      temp_in       = temp_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_avg_in    = rsp_avg_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      log_start     = 1'b0;
      log_x         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (taken_next >= n_eff) begin
                  div_start    = 1'b1;
                  div_dividend = DIV_W'(sum_ff) + DIV_W'(s_sat);
                  div_divisor  = DIV_W'(taken_next);
                  sum_in       = '0;
                  taken_in     = '0;
                  state_in     = S_AVG;
               end else begin
                  sum_in   = sum_ff + SUM_W'(s_sat);
                  taken_in = taken_ff + 1'b1;
               end
            end
         end
         S_AVG: begin
            if (div_done) begin
               avg_in = div_q[9:0];
               if ({6'd0, div_q[9:0]} >= FS) begin
                  status_in = STATUS_OPEN;
                  res_in    = RES_MAX;
                  temp_in   = TEMP_LOW;
                  state_in  = S_OUT;
               end else if (div_q[9:0] == '0) begin
                  status_in = STATUS_SHORT;
                  res_in    = '0;
                  temp_in   = TEMP_LOW;
                  state_in  = S_OUT;
               end else begin
                  status_in    = STATUS_OK;
                  div_start    = 1'b1;
                  div_dividend = DIV_W'(30'(series_ff) * 30'(div_q[9:0]));
                  div_divisor  = DIV_W'(FS - {6'd0, div_q[9:0]});
                  state_in     = S_RES;
               end
            end
         end
         S_RES: begin
            if (div_done) begin
               res_in = (div_q[29:24] != '0) ? RES_MAX : div_q[23:0];
               if (div_q[29:0] == '0) begin
                  temp_in  = TEMP_LOW;
                  state_in = S_OUT;
               end else begin
                  log_start = 1'b1;
                  log_x     = MANT_W'(div_q[29:0]);
                  state_in  = S_LOGR;
               end
            end
         end
         S_LOGR: begin
            if (log_done) begin
               lr_in     = log_q;
               log_start = 1'b1;
               log_x     = MANT_W'(r0_eff);
               state_in  = S_LOG0;
            end
         end
         S_LOG0: begin
            if (log_done) begin
               d_in     = $signed({1'b0, lr_ff}) - $signed({1'b0, log_q});
               state_in = S_LN;
            end
         end
         S_LN: begin
            l_in     = d_ff[25] ? -$signed(mag_l) : $signed(mag_l);
            tnb_in   = 30'(tn_eff) * 30'(beta_eff);
            state_in = S_PROD;
         end
         S_PROD: begin
            num_in   = {37'(tnb_ff) * 37'd100, 20'd0};
            state_in = S_DEN;
         end
         S_DEN: begin
            den_in   = $signed({3'd0, b100, 20'd0}) + 44'(tnl);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (den_ff == '0) begin
               temp_in  = TEMP_HIGH;
               state_in = S_OUT;
            end else if (den_ff[43]) begin
               temp_in  = TEMP_LOW;
               state_in = S_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = {1'b0, num_ff} + DIV_W'(den_ff[43:1]);
               div_divisor  = DIV_W'(den_ff);
               state_in     = S_TDIV;
            end
         end
         S_TDIV: begin
            if (div_done) begin
               if (tc > TC_HIGH) begin
                  temp_in = TEMP_HIGH;
               end else begin
                  temp_in = $signed(tc[17:0] - KELVIN_OFFSET);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = avg_ff;
               rsp_res_in    = res_ff;
               rsp_temp_in   = temp_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall               = (state_ff != S_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_averaged_adc        = rsp_avg_ff;
   assign rsp_resistance_ohms     = rsp_res_ff;
   assign rsp_temperature_centi_c = rsp_temp_ff;
   assign rsp_status              = rsp_status_ff;

   a_open_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OPEN) |-> (rsp_resistance_ohms == RES_MAX))
      else $error("open status without saturated resistance");
   a_short_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_SHORT) |->
      (rsp_resistance_ohms == '0 && rsp_averaged_adc == '0))
      else $error("short status with nonzero resistance or mean");
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_centi_c >= TEMP_LOW &&
                     rsp_temperature_centi_c <= TEMP_HIGH))
      else $error("temperature out of range");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_AVG || state_ff == S_RES || state_ff == S_TDIV))
      else $error("divider finished outside a divide step");

endmodule

/* dv/tb_thermistor_beta_temperature.sv */
// Testbench for thermistor_beta_temperature: directed table, then random phases
// under a bit-exact fixed-point predictor. Depends on rtl/tbt_pkg.sv and the block.
`timescale 1ns / 1ps
module tb_thermistor_beta_temperature;
   import tbt_pkg::*;

   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;
   localparam int FULL_SCALE = 1023;
   localparam int SETTLE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [9:0]         avg;
      logic [23:0]        res;
      logic signed [17:0] temp;
      logic [1:0]         status;
   } reading_type;

   typedef struct {
      logic [9:0]  sample;
      bit          typed;
      reading_type want;
   } table_row_type;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic [9:0]         req_adc_sample;
   logic               rsp_valid, rsp_stall;
   logic [9:0]         rsp_averaged_adc;
   logic [23:0]        rsp_resistance_ohms;
   logic signed [17:0] rsp_temperature_centi_c;
   logic [1:0]         rsp_status;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [23:0]        csr_wr_data;

   thermistor_beta_temperature i_dut (.*);

   // predictor copy of registers and accumulator
   longint unsigned cfg_count, cfg_series, cfg_r0, cfg_beta, cfg_t0;
   longint unsigned acc_sum, acc_taken;

   reading_type pending_readings[$];
   int          fail_count, items_sent, readings_checked, idle_cycles;
   bit          hold_rsp, hold_used, no_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint log2_q20(longint unsigned x);
      int k;
      longint unsigned m;
      longint frac;
      k = 0;
      frac = 0;
      while (k < 63 && (x >> (k + 1)) != 0) k++;
      m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(k) * (64'sd1 << 20) + frac;
   endfunction

   function automatic longint beta_temperature(longint unsigned r);
      longint unsigned r0, mag_u;
      longint b, tn, d, l, num, den, t;
      r0 = cfg_r0 ? cfg_r0 : 1;
      b = cfg_beta ? longint'(cfg_beta) : 1;
      tn = cfg_t0 ? longint'(cfg_t0) : 1;
      if (r == 0) return TEMP_LOW;
      d = log2_q20(r) - log2_q20(r0);
      mag_u = d < 0 ? longint'(-d) : longint'(d);
      mag_u = (mag_u * 64'd744261118) >> 30;
      l = d < 0 ? -longint'(mag_u) : longint'(mag_u);
      num = 100 * tn * b * (64'sd1 << 20);
      den = 100 * b * (64'sd1 << 20) + tn * l;
      if (den == 0) return TEMP_HIGH;
      if (den < 0) return TEMP_LOW;
      t = (num + den / 2) / den - 27315;
      if (t < TEMP_LOW) t = TEMP_LOW;
      if (t > TEMP_HIGH) t = TEMP_HIGH;
      return t;
   endfunction

   function automatic bit predict_reading(input logic [9:0] s, output reading_type o);
      longint unsigned n, avg, r;
      longint t;
      n = cfg_count == 0 ? 1 : (cfg_count > 64 ? 64 : cfg_count);
      acc_sum += s;
      acc_taken++;
      o = '{default: '0};
      if (acc_taken < n) return 1'b0;
      avg = acc_sum / acc_taken;
      acc_sum = 0;
      acc_taken = 0;
      o.avg = avg[9:0];
      if (avg >= FULL_SCALE) begin
         o.status = STATUS_OPEN;
         o.res = RES_MAX;
         o.temp = TEMP_LOW;
      end else if (avg == 0) begin
         o.status = STATUS_SHORT;
         o.res = '0;
         o.temp = TEMP_LOW;
      end else begin
         o.status = STATUS_OK;
         r = (cfg_series * avg) / (FULL_SCALE - avg);
         o.res = r > RES_MAX ? RES_MAX : r[23:0];
         t = beta_temperature(r);
         o.temp = t[17:0];
      end
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input longint unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[23:0];
      case (idx)
         REG_SAMPLE_COUNT: cfg_count = value & 64'h7F;
         REG_SERIES:       cfg_series = value & 64'hFFFFF;
         REG_NOMINAL_RES:  cfg_r0 = value & 64'hFFFFFF;
         REG_BETA:         cfg_beta = value & 64'h3FFF;
         REG_NOMINAL_TEMP: cfg_t0 = value & 64'hFFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input logic [9:0] s, input bit typed = 0,
                            input reading_type want = '{default: '0});
      int gap, r;
      reading_type p;
      r = $urandom_range(0, 99);
      gap = (no_gaps || r < 60) ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_reading(s, p)) pending_readings.push_back(typed ? want : p);
   endtask

   function automatic logic [9:0] random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 10'd0;
      if (r < 20) return 10'd1023;
      if (r < 30) return 10'($urandom_range(0, 8));
      if (r < 40) return 10'($urandom_range(1015, 1023));
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic longint unsigned pick(longint unsigned lo, longint unsigned hi,
                                            longint unsigned top);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return lo;
      if (r == 1) return hi;
      if (r == 2) return top;
      return lo + ({$urandom, $urandom} % (hi - lo + 1));
   endfunction

   task automatic random_config();
      int r;
      r = $urandom_range(0, 9);
      write_reg(REG_SAMPLE_COUNT, r < 6 ? $urandom_range(1, 8) :
                (r < 8 ? $urandom_range(1, 64) : pick(0, 64, 127)));
      write_reg(REG_SERIES, pick(1, 1000000, 20'hFFFFF));
      write_reg(REG_NOMINAL_RES, pick(1, 10000000, 24'hFFFFFF));
      write_reg(REG_BETA, pick(1, 10000, 14'h3FFF));
      write_reg(REG_NOMINAL_TEMP, pick(1, 50000, 16'hFFFF));
   endtask

   // response side: random stall runs, plus one long hold-off on request
   initial begin
      int r, n;
      bit st;
      hold_used = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_rsp && !hold_used) begin
            hold_used = 1'b1;
            st = 1'b1;
            n = 2000;
         end else if (r < 15) begin
            st = 1'b1;
            n = $urandom_range(1, 3);
         end else if (r < 18) begin
            st = 1'b1;
            n = $urandom_range(20, 80);
         end else begin
            st = 1'b0;
            n = $urandom_range(1, 30);
         end
         rsp_stall <= st;
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      reading_type w;
      if (rsp_valid && !rsp_stall && !reset) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected result: avg %0d", rsp_averaged_adc);
            fail_count++;
         end else begin
            w = pending_readings.pop_front();
            readings_checked++;
            if (rsp_averaged_adc !== w.avg) begin
               $error("averaged_adc expected %0d got %0d", w.avg, rsp_averaged_adc);
               fail_count++;
            end
            if (rsp_resistance_ohms !== w.res) begin
               $error("resistance_ohms expected %0d got %0d", w.res, rsp_resistance_ohms);
               fail_count++;
            end
            if (rsp_temperature_centi_c !== w.temp) begin
               $error("temperature_centi_c expected %0d got %0d", w.temp,
                      rsp_temperature_centi_c);
               fail_count++;
            end
            if (rsp_status !== w.status) begin
               $error("status expected %0d got %0d", w.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("thermistor_beta_temperature test failed");
         $finish;
      end
   end

   initial begin
      table_row_type rows[$];
      reading_type open_r, short_r, zero_r;
      open_r = '{avg: 10'd1023, res: RES_MAX, temp: TEMP_LOW, status: STATUS_OPEN};
      short_r = '{avg: 10'd0, res: 24'd0, temp: TEMP_LOW, status: STATUS_SHORT};
      zero_r = '{avg: 10'd1, res: 24'd0, temp: TEMP_LOW, status: STATUS_OK};
      rows = '{
         '{10'd1023, 1'b1, open_r}, '{10'd0, 1'b1, short_r},
         '{10'd1, 1'b0, open_r}, '{10'd1022, 1'b0, open_r},
         '{10'd512, 1'b0, open_r}, '{10'h2AA, 1'b0, open_r},
         '{10'h155, 1'b0, open_r}, '{10'd797, 1'b0, open_r}
      };
      items_sent = 0;
      hold_rsp = 1'b0;
      no_gaps = 1'b0;
      cfg_count = 8; cfg_series = 4700; cfg_r0 = 100000; cfg_beta = 3950; cfg_t0 = 29815;
      acc_sum = 0;
      acc_taken = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_adc_sample <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= REG_SAMPLE_COUNT;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: open, short, then a mixed set
      for (int i = 0; i < 8; i++) send_item(10'd1023, i == 7, open_r);
      for (int i = 0; i < 8; i++) send_item(10'd0, i == 7, short_r);
      for (int i = 0; i < 8; i++) send_item(random_sample());
      wait_idle();

      write_reg(REG_SAMPLE_COUNT, 1);
      foreach (rows[i]) send_item(rows[i].sample, rows[i].typed, rows[i].want);
      wait_idle();

      // zero resistance from a nonzero mean
      write_reg(REG_SERIES, 1);
      send_item(10'd1, 1'b1, zero_r);
      wait_idle();

      // negative denominator, then zero registers read as one
      write_reg(REG_SERIES, 1022);
      write_reg(REG_NOMINAL_RES, 10000000);
      write_reg(REG_BETA, 1);
      write_reg(REG_NOMINAL_TEMP, 50000);
      send_item(10'd1);
      send_item(10'd1000);
      wait_idle();
      write_reg(REG_NOMINAL_RES, 0);
      write_reg(REG_BETA, 0);
      write_reg(REG_NOMINAL_TEMP, 0);
      write_reg(REG_UNUSED_LO, 24'hFFFFFF);
      write_reg(REG_UNUSED_HI, 24'h123456);
      send_item(10'd300);
      send_item(10'd1023);
      wait_idle();

      // count of zero, count beyond the maximum, count lowered mid-collection
      write_reg(REG_SAMPLE_COUNT, 0);
      send_item(10'd77);
      wait_idle();
      write_reg(REG_SAMPLE_COUNT, 127);
      for (int i = 0; i < 64; i++) send_item(random_sample());
      for (int i = 0; i < 10; i++) send_item(random_sample());
      wait_idle();
      write_reg(REG_SAMPLE_COUNT, 4);
      send_item(random_sample());
      wait_idle();

      // long response hold-off while requests keep coming
      random_config();
      write_reg(REG_SAMPLE_COUNT, 1);
      hold_rsp = 1'b1;
      no_gaps = 1'b1;
      for (int i = 0; i < 20; i++) send_item(random_sample());
      no_gaps = 1'b0;
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         random_config();
         no_gaps = (ph % 4 == 3);
         for (int i = 0; i < 33; i++) send_item(random_sample());
         wait_idle();
      end

      $display("covered %0d items and %0d results over directed corners and 10 random setups",
               items_sent, readings_checked);
      if (fail_count == 0)
         $display("thermistor_beta_temperature test passed");
      else
         $display("thermistor_beta_temperature test failed");
      $finish;
   end
endmodule
